// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HHFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HHFS_ASSERT_NEVER(lbl, expr, msg) \
  `HHFS_ASSERT(lbl, !(expr), msg)

`else

`define HHFS_ASSERT(lbl, prop, msg)

`define HHFS_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: rtl/hhfs_pkg.sv
// ---------------------------------------------------------------------------
// hhfs_pkg
// shared types, characters and helpers of the header field splitter
// ---------------------------------------------------------------------------
package hhfs_pkg;

  localparam logic [15:0] MaxBytes = 16'hFFFF;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;

  typedef enum logic [5:0] {
    MODE_SKIP    = 6'b000001,
    MODE_NAME    = 6'b000010,
    MODE_SEEKVAL = 6'b000100,
    MODE_VALUE   = 6'b001000,
    MODE_DONE    = 6'b010000,
    MODE_STOPPED = 6'b100000
  } hhfs_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_request;
  } hhfs_item_t;

  typedef struct packed {
    logic        has_header;
    logic [15:0] name_start;
    logic [15:0] name_end;
    logic [15:0] value_start;
    logic [15:0] value_end;
    logic        section_end;
    logic        overflow;
  } hhfs_result_t;

  // space, tab, lf, vt, ff, cr
  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

endpackage

// File: rtl/hhfs_if.sv
// ---------------------------------------------------------------------------
// hhfs_if
// valid/ready channels for request bytes and header results
// ---------------------------------------------------------------------------
interface hhfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_request;

  modport source (output valid, output data_byte, output start_of_request, input ready);
  modport sink   (input valid, input data_byte, input start_of_request, output ready);
endinterface

interface hhfs_out_if;
  logic        valid;
  logic        ready;
  logic        has_header;
  logic [15:0] name_start;
  logic [15:0] name_end;
  logic [15:0] value_start;
  logic [15:0] value_end;
  logic        section_end;
  logic        overflow;

  modport source (
    output valid, output has_header, output name_start, output name_end,
    output value_start, output value_end, output section_end, output overflow,
    input  ready
  );
  modport sink (
    input  valid, input has_header, input name_start, input name_end,
    input  value_start, input value_end, input section_end, input overflow,
    output ready
  );
endinterface

// File: rtl/hhfs_in_stage.sv
// ---------------------------------------------------------------------------
// hhfs_in_stage
// input register for one request byte
// ---------------------------------------------------------------------------
module hhfs_in_stage
  import hhfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  hhfs_in_if.sink    in_if,
  input  logic       fire,
  output logic       item_valid,
  output hhfs_item_t item
);

  logic       valid_r;
  hhfs_item_t item_r;

  // holds while the parser cannot take the item
  assign in_if.ready = !valid_r || fire;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      item_r.data_byte        <= in_if.data_byte;
      item_r.start_of_request <= in_if.start_of_request;
    end
  end

endmodule

// File: rtl/hhfs_parser.sv
// ---------------------------------------------------------------------------
// hhfs_parser
// per-byte header state update and result forming
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hhfs_parser
  import hhfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  hhfs_item_t   item,
  output logic         res_valid,
  output hhfs_result_t res
);

  hhfs_mode_t  mode_r, mode_nxt;
  logic [15:0] position_r, position_nxt;
  logic [15:0] name_begin_r, name_begin_nxt;
  logic [15:0] name_colon_r, name_colon_nxt;
  logic [15:0] value_begin_r, value_begin_nxt;
  logic [15:0] value_lpo_r, value_lpo_nxt;
  logic        nl_pending_r, nl_pending_nxt;
  logic        cr_seen_r, cr_seen_nxt;
  logic [1:0]  le_count_r, le_count_nxt;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] pos;
    logic [15:0] pos_inc;
    logic        ws;
    logic        ends;
    hhfs_mode_t  m;

    b   = item.data_byte;
    ws  = is_ws(b);
    res = '0;
    res_valid = 1'b0;

    // start of request clears everything before this byte is looked at
    if (item.start_of_request) begin
      mode_nxt        = MODE_SKIP;
      position_nxt    = '0;
      name_begin_nxt  = '0;
      name_colon_nxt  = '0;
      value_begin_nxt = '0;
      value_lpo_nxt   = '0;
      nl_pending_nxt  = 1'b0;
      cr_seen_nxt     = 1'b0;
      le_count_nxt    = '0;
    end else begin
      mode_nxt        = mode_r;
      position_nxt    = position_r;
      name_begin_nxt  = name_begin_r;
      name_colon_nxt  = name_colon_r;
      value_begin_nxt = value_begin_r;
      value_lpo_nxt   = value_lpo_r;
      nl_pending_nxt  = nl_pending_r;
      cr_seen_nxt     = cr_seen_r;
      le_count_nxt    = le_count_r;
    end

    pos     = position_nxt;
    pos_inc = pos + 16'd1;
    ends    = 1'b0;
    m       = mode_nxt;

    if (mode_nxt == MODE_DONE || mode_nxt == MODE_STOPPED) begin
      // ignored until the next request
    end else if (pos >= MaxBytes) begin
      mode_nxt     = MODE_STOPPED;
      res.overflow = 1'b1;
      res_valid    = 1'b1;
    end else begin
      position_nxt = pos_inc;

      if (b == ChLf) begin
        if (le_count_nxt != 2'd2) begin
          le_count_nxt = le_count_nxt + 2'd1;
        end
      end else if (b == ChCr) begin
        if (cr_seen_nxt) begin
          le_count_nxt = '0;
        end
      end else begin
        le_count_nxt = '0;
      end
      cr_seen_nxt = (b == ChCr);
      ends        = (le_count_nxt == 2'd2);

      // a non-whitespace byte after lf closes the value, else the line folds
      if (m == MODE_VALUE && nl_pending_nxt) begin
        nl_pending_nxt = 1'b0;
        if (!ws) begin
          res.has_header  = 1'b1;
          res.name_start  = name_begin_nxt;
          res.name_end    = name_colon_nxt;
          res.value_start = value_begin_nxt;
          res.value_end   = value_lpo_nxt;
          res_valid       = 1'b1;
          name_begin_nxt  = pos;
          m               = MODE_NAME;
        end
      end

      mode_nxt = m;
      unique case (m)
        MODE_SKIP: begin
          if (b == ChLf) begin
            mode_nxt       = MODE_NAME;
            name_begin_nxt = pos_inc;
          end
        end
        MODE_NAME: begin
          if (b == ChColon) begin
            name_colon_nxt = pos;
            mode_nxt       = MODE_SEEKVAL;
          end
        end
        MODE_SEEKVAL: begin
          if (!ws) begin
            value_begin_nxt = pos;
            value_lpo_nxt   = pos_inc;
            mode_nxt        = MODE_VALUE;
          end
        end
        MODE_VALUE: begin
          if (b == ChLf) begin
            if (ends) begin
              res.has_header  = 1'b1;
              res.name_start  = name_begin_nxt;
              res.name_end    = name_colon_nxt;
              res.value_start = value_begin_nxt;
              res.value_end   = value_lpo_nxt;
              res_valid       = 1'b1;
            end else begin
              nl_pending_nxt = 1'b1;
            end
          end else if (!ws) begin
            value_lpo_nxt = pos_inc;
          end
        end
        default: begin
        end
      endcase

      if (ends) begin
        res.section_end = 1'b1;
        res_valid       = 1'b1;
        mode_nxt        = MODE_DONE;
        nl_pending_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_SKIP;
      position_r    <= '0;
      name_begin_r  <= '0;
      name_colon_r  <= '0;
      value_begin_r <= '0;
      value_lpo_r   <= '0;
      nl_pending_r  <= 1'b0;
      cr_seen_r     <= 1'b0;
      le_count_r    <= '0;
    end else if (fire) begin
      mode_r        <= mode_nxt;
      position_r    <= position_nxt;
      name_begin_r  <= name_begin_nxt;
      name_colon_r  <= name_colon_nxt;
      value_begin_r <= value_begin_nxt;
      value_lpo_r   <= value_lpo_nxt;
      nl_pending_r  <= nl_pending_nxt;
      cr_seen_r     <= cr_seen_nxt;
      le_count_r    <= le_count_nxt;
    end
  end

  `HHFS_ASSERT(a_halted_holds,
    fire && !item.start_of_request && (mode_r == MODE_DONE || mode_r == MODE_STOPPED)
      |=> $stable(mode_r) && $stable(position_r),
    "parser left a halted mode without a new request")

  `HHFS_ASSERT(a_overflow_stops,
    fire && res_valid && res.overflow |=> mode_r == MODE_STOPPED,
    "overflow item did not stop the parser")

  `HHFS_ASSERT(a_section_done,
    fire && res_valid && res.section_end |=> mode_r == MODE_DONE,
    "section end did not finish the parser")

  `HHFS_ASSERT_NEVER(a_header_no_overflow,
    res_valid && res.has_header && res.overflow,
    "header item also flagged overflow")

endmodule

// File: rtl/hhfs_out_stage.sv
// ---------------------------------------------------------------------------
// hhfs_out_stage
// result register driving the output channel
// ---------------------------------------------------------------------------
module hhfs_out_stage
  import hhfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  hhfs_out_if.source   out_if,
  input  logic         fire,
  input  logic         res_valid,
  input  hhfs_result_t res,
  output logic         take
);

  logic         valid_r;
  hhfs_result_t res_r;

  // free, or being emptied this cycle
  assign take = !valid_r || out_if.ready;

  assign out_if.valid       = valid_r;
  assign out_if.has_header  = res_r.has_header;
  assign out_if.name_start  = res_r.name_start;
  assign out_if.name_end    = res_r.name_end;
  assign out_if.value_start = res_r.value_start;
  assign out_if.value_end   = res_r.value_end;
  assign out_if.section_end = res_r.section_end;
  assign out_if.overflow    = res_r.overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= res_valid;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// File: rtl/http_header_field_splitter_core.sv
// path: an accepted byte is held in the input register, parsed, and its result captured in the result register
// throughput: one byte per cycle unless a result stalls, set by the parser state update
// a stalled result holds the input register; the next byte waits on the input channel
// reset: synchronous active-low, empties both register stages and returns the
// parser to skipping the request line; no clearing pass
// ---------------------------------------------------------------------------
// http_header_field_splitter_core
// splits http header fields from a byte stream into name and value offsets
// ---------------------------------------------------------------------------
module http_header_field_splitter_core
  import hhfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  hhfs_in_if.sink    in_if,
  hhfs_out_if.source out_if
);

  logic         item_valid;
  hhfs_item_t   item;
  logic         take;
  logic         fire;
  logic         res_valid;
  hhfs_result_t res;

  assign fire = item_valid && take;

  hhfs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  hhfs_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  hhfs_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_if    (out_if),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .take      (take)
  );

endmodule
